>>> rtl/aclp_pkg.sv
// ----------------------------------------------------------------------------
// aclp_pkg
// Shared types, character codes and sizes of the AT command line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package aclp_pkg;

    // character codes
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_QM = 8'h3F;

    // results one byte can cause, and the size of the queue between the parts
    localparam int MAX_RES   = 4;
    localparam int CNT_W     = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;

    typedef enum logic [1:0] {
        KIND_CMD   = 2'd0,
        KIND_PARAM = 2'd1,
        KIND_EOL   = 2'd2
    } t_item_kind;

    typedef enum logic [1:0] {
        TYPE_TEST = 2'd0,
        TYPE_GET  = 2'd1,
        TYPE_SET  = 2'd2
    } t_line_type;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_CMD    = 2'd1,
        PH_PARAM  = 2'd2,
        PH_TEST   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        t_item_kind kind;
        t_line_type ltype;
        logic       last;
    } t_result;

    // all results caused by one input byte
    typedef struct packed {
        logic [CNT_W-1:0]      count;
        t_result [MAX_RES-1:0] res;
    } t_entry;

    // queue status seen by the two parts
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // characters of the "AT+" line prefix
    function automatic logic [7:0] prefix_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h41;
            2'd1:    c = 8'h54;
            2'd2:    c = 8'h2B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/aclp_ifs.sv
// ----------------------------------------------------------------------------
// aclp channel interfaces
// Byte input channel and tagged result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface aclp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface aclp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] item_kind;
    logic [1:0] line_type;
    logic       last_of_run;

    modport source (output valid, output out_byte, output item_kind,
                    output line_type, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input item_kind,
                    input line_type, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/aclp_front.sv
// ----------------------------------------------------------------------------
// aclp_front
// Accepts raw bytes, tracks the line state and builds the group of results
// that each byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module aclp_front (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire  [7:0]                i_byte,
    input  aclp_pkg::t_q_stat         i_q_stat,
    output logic                      o_push,
    output aclp_pkg::t_entry          o_entry
);

    aclp_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_pm, n_pm;
    logic             r_qh, n_qh;
    logic             r_ch, n_ch;

    logic [aclp_pkg::CNT_W-1:0] v_n;
    logic [aclp_pkg::CNT_W-1:0] v_last_idx;
    aclp_pkg::t_result [aclp_pkg::MAX_RES-1:0] v_res;
    logic [1:0]       v_tk_v;
    logic [7:0]       v_tk_b [2];
    logic [7:0]       v_b;
    logic             v_acc;

    assign o_ready = !i_q_stat.full;
    assign v_acc   = i_valid && o_ready;

    // classify the byte against the line state
    always_comb begin
        n_phase = r_phase;
        n_pm    = r_pm;
        n_qh    = r_qh;
        n_ch    = r_ch;
        v_n     = '0;
        v_res   = '0;
        v_tk_v  = 2'b00;
        v_tk_b[0] = aclp_pkg::CH_CR;
        v_tk_b[1] = i_byte;
        v_b     = '0;

        if (i_byte == aclp_pkg::CH_LF) begin
            // line end: pending prefix characters, then the end-of-line item
            if (r_phase == aclp_pkg::PH_PREFIX) begin
                for (int i = 0; i < 2; i++) begin
                    if (2'(i) < r_pm) begin
                        v_res[v_n[1:0]].data = aclp_pkg::prefix_char(2'(i));
                        v_res[v_n[1:0]].kind = aclp_pkg::KIND_CMD;
                        v_n = v_n + 3'd1;
                    end
                end
            end
            v_res[v_n[1:0]].kind = aclp_pkg::KIND_EOL;
            if (r_phase == aclp_pkg::PH_CMD) begin
                v_res[v_n[1:0]].ltype = aclp_pkg::TYPE_GET;
            end else if (r_phase == aclp_pkg::PH_PARAM) begin
                v_res[v_n[1:0]].ltype = aclp_pkg::TYPE_SET;
            end else begin
                v_res[v_n[1:0]].ltype = aclp_pkg::TYPE_TEST;
            end
            v_n     = v_n + 3'd1;
            n_phase = aclp_pkg::PH_PREFIX;
            n_pm    = '0;
            n_qh    = 1'b0;
            n_ch    = 1'b0;
        end else if (i_byte == aclp_pkg::CH_CR) begin
            // a second carriage return releases whatever was held
            if (r_ch) begin
                if (r_qh) begin
                    v_res[v_n[1:0]].data = aclp_pkg::CH_QM;
                    v_res[v_n[1:0]].kind = aclp_pkg::KIND_CMD;
                    v_n  = v_n + 3'd1;
                    n_qh = 1'b0;
                end
                v_tk_v[0] = 1'b1;
            end
            n_ch = 1'b1;
        end else begin
            // ordinary byte: release held bytes, then take the byte
            if (r_qh) begin
                v_res[v_n[1:0]].data = aclp_pkg::CH_QM;
                v_res[v_n[1:0]].kind = aclp_pkg::KIND_CMD;
                v_n  = v_n + 3'd1;
                n_qh = 1'b0;
            end
            v_tk_v[0] = r_ch;
            n_ch      = 1'b0;
            v_tk_v[1] = 1'b1;
        end

        // take up to two content bytes in order
        for (int k = 0; k < 2; k++) begin
            if (v_tk_v[k]) begin
                v_b = v_tk_b[k];
                case (n_phase)
                    aclp_pkg::PH_PREFIX: begin
                        if (v_b == aclp_pkg::prefix_char(n_pm)) begin
                            if (n_pm == 2'd2) begin
                                n_phase = aclp_pkg::PH_CMD;
                                n_pm    = '0;
                            end else begin
                                n_pm = n_pm + 2'd1;
                            end
                        end else begin
                            for (int i = 0; i < 2; i++) begin
                                if (2'(i) < n_pm) begin
                                    v_res[v_n[1:0]].data = aclp_pkg::prefix_char(2'(i));
                                    v_res[v_n[1:0]].kind = aclp_pkg::KIND_CMD;
                                    v_n = v_n + 3'd1;
                                end
                            end
                            v_res[v_n[1:0]].data = v_b;
                            v_res[v_n[1:0]].kind = aclp_pkg::KIND_CMD;
                            v_n     = v_n + 3'd1;
                            n_phase = aclp_pkg::PH_TEST;
                            n_pm    = '0;
                        end
                    end
                    aclp_pkg::PH_CMD: begin
                        if (v_b == aclp_pkg::CH_QM) begin
                            n_qh = 1'b1;
                        end else if (v_b == aclp_pkg::CH_EQ) begin
                            n_phase = aclp_pkg::PH_PARAM;
                        end else begin
                            v_res[v_n[1:0]].data = v_b;
                            v_res[v_n[1:0]].kind = aclp_pkg::KIND_CMD;
                            v_n = v_n + 3'd1;
                        end
                    end
                    aclp_pkg::PH_PARAM: begin
                        v_res[v_n[1:0]].data = v_b;
                        v_res[v_n[1:0]].kind = aclp_pkg::KIND_PARAM;
                        v_n = v_n + 3'd1;
                    end
                    default: begin
                        v_res[v_n[1:0]].data = v_b;
                        v_res[v_n[1:0]].kind = aclp_pkg::KIND_CMD;
                        v_n = v_n + 3'd1;
                    end
                endcase
            end
        end

        // mark the final result of the group
        v_last_idx = v_n - 3'd1;
        if (v_n != '0) begin
            v_res[v_last_idx[1:0]].last = 1'b1;
        end
    end

    assign o_push        = v_acc && (v_n != '0);
    assign o_entry.count = v_n;
    assign o_entry.res   = v_res;

    // line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= aclp_pkg::PH_PREFIX;
            r_pm    <= '0;
            r_qh    <= 1'b0;
            r_ch    <= 1'b0;
        end else if (v_acc) begin
            r_phase <= n_phase;
            r_pm    <= n_pm;
            r_qh    <= n_qh;
            r_ch    <= n_ch;
        end
    end

endmodule

`default_nettype wire

>>> rtl/aclp_queue.sv
// ----------------------------------------------------------------------------
// aclp_queue
// Short queue of result groups between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module aclp_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  aclp_pkg::t_entry    i_entry,
    input  wire                 i_pop,
    output aclp_pkg::t_entry    o_head,
    output aclp_pkg::t_q_stat   o_stat
);

    aclp_pkg::t_entry r_mem [aclp_pkg::Q_DEPTH];
    logic [aclp_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [aclp_pkg::Q_AW:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (aclp_pkg::Q_AW+1)'(aclp_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rp];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + (aclp_pkg::Q_AW)'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + (aclp_pkg::Q_AW)'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (aclp_pkg::Q_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (aclp_pkg::Q_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/aclp_back.sv
// ----------------------------------------------------------------------------
// aclp_back
// Walks the head results, one a cycle unless stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aclp_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  aclp_pkg::t_entry    i_head,
    input  aclp_pkg::t_q_stat   i_q_stat,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output aclp_pkg::t_result   o_res
);

    logic [1:0]        r_idx;
    logic              r_valid;
    aclp_pkg::t_result r_res;
    logic              v_load;
    logic              v_at_end;

    assign v_load   = !i_q_stat.empty && (!r_valid || i_ready);
    assign v_at_end = ({1'b0, r_idx} == (i_head.count - 3'd1));
    assign o_pop    = v_load && v_at_end;
    assign o_valid  = r_valid;
    assign o_res    = r_res;

    // result index within the head group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (v_load) begin
                r_idx   <= v_at_end ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (v_load) begin
            r_res <= i_head.res[r_idx];
        end
    end

endmodule

`default_nettype wire

>>> rtl/at_command_line_parser_top.sv
// ----------------------------------------------------------------------------
// at_command_line_parser_top
// AT command line classifier: raw serial bytes in, tagged line bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one raw byte per request. o_out carries tagged results:
//   command bytes, parameter bytes and one end-of-line item per LF that
//   carries the line type (test, get, set). last_of_run marks the final
//   result caused by an input byte; a byte may cause no result at all.
//   The front part takes one byte per cycle unless the queue is full, and
//   places a byte's results, up to four, as one group in a four-group queue.
//   The back part moves one result per cycle into the output register while
//   the receiver takes them; byte throughput is one per cycle as long as
//   bytes average one result or less and the receiver does not stall.
//   A byte's group is written into the queue at the edge that accepts it,
//   and its results then move from the queue head into the output register.
//   When the receiver stalls, the output register holds its result and the
//   queue keeps filling; i_in.ready drops only once four groups wait.
//   Reset (synchronous, active low) empties the queue and output register
//   and returns the line state to the start of a line.
// ----------------------------------------------------------------------------
`default_nettype none

module at_command_line_parser_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    aclp_in_if.sink     i_in,
    aclp_out_if.source  o_out
);

    aclp_pkg::t_q_stat q_stat;
    aclp_pkg::t_entry  push_entry;
    aclp_pkg::t_entry  head_entry;
    aclp_pkg::t_result out_res;
    logic              push;
    logic              pop;

    // front: accept and classify
    aclp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_byte   (i_in.in_byte),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    // queue of result groups
    aclp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_stat  (q_stat)
    );

    // back: emit results
    aclp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_entry),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_res    (out_res)
    );

    assign o_out.out_byte    = out_res.data;
    assign o_out.item_kind   = out_res.kind;
    assign o_out.line_type   = out_res.ltype;
    assign o_out.last_of_run = out_res.last;

endmodule

`default_nettype wire
